@@ design/assert_macros.svh @@
// assertion helpers for the checker file tsp_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define TSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, held off while reset is low
`define TSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ design/tsp_pkg.sv @@
package tsp_pkg;

    localparam int COUNT_BITS     = 24;
    localparam int FRAC_BITS      = 16;
    localparam int RATIO_BITS     = FRAC_BITS + 1;
    localparam int DEN_BITS       = FRAC_BITS + 2;
    localparam int MIN_OCC_BITS   = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = (COUNT_BITS > MIN_OCC_BITS) ? COUNT_BITS : MIN_OCC_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOTAL_HAM  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOTAL_SPAM = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_OCC    = CFG_INDEX_BITS'(2);

    localparam logic [COUNT_BITS-1:0]   TOTAL_RESET   = COUNT_BITS'(1);
    localparam logic [MIN_OCC_BITS-1:0] MIN_OCC_RESET = MIN_OCC_BITS'(5);

    localparam logic [RATIO_BITS-1:0] ONE_FX  = RATIO_BITS'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0]  HALF_FX = FRAC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [FRAC_BITS-1:0]  PROB_LO = FRAC_BITS'((2 ** FRAC_BITS) / 100);
    localparam logic [FRAC_BITS-1:0]  PROB_HI = FRAC_BITS'(((2 ** FRAC_BITS) * 99) / 100);

    // item in flight through the two count/total dividers
    typedef struct packed {
        logic                  insuf;
        logic                  b_zero;
        logic                  b_one;
        logic                  g_zero;
        logic                  g_one;
        logic [COUNT_BITS-1:0] rem_b;
        logic [COUNT_BITS-1:0] rem_g;
        logic [FRAC_BITS-1:0]  q_b;
        logic [FRAC_BITS-1:0]  q_g;
    } ratio_item_t;

    // item in flight through the probability divider
    typedef struct packed {
        logic                 insuf;
        logic                 half;
        logic                 hi;
        logic [DEN_BITS-1:0]  rem;
        logic [DEN_BITS-1:0]  den;
        logic [FRAC_BITS-1:0] q;
    } prob_item_t;

    // one restoring step on each ratio
    function automatic ratio_item_t ratio_step(input ratio_item_t it,
                                               input logic [COUNT_BITS-1:0] ts,
                                               input logic [COUNT_BITS-1:0] th);
        ratio_item_t         nx;
        logic [COUNT_BITS:0] rb2;
        logic [COUNT_BITS:0] rg2;
        nx  = it;
        rb2 = {it.rem_b, 1'b0};
        rg2 = {it.rem_g, 1'b0};
        if (rb2 >= {1'b0, ts})
        begin
            nx.rem_b = COUNT_BITS'(rb2 - {1'b0, ts});
            nx.q_b   = {it.q_b[FRAC_BITS-2:0], 1'b1};
        end
        else
        begin
            nx.rem_b = rb2[COUNT_BITS-1:0];
            nx.q_b   = {it.q_b[FRAC_BITS-2:0], 1'b0};
        end
        if (rg2 >= {1'b0, th})
        begin
            nx.rem_g = COUNT_BITS'(rg2 - {1'b0, th});
            nx.q_g   = {it.q_g[FRAC_BITS-2:0], 1'b1};
        end
        else
        begin
            nx.rem_g = rg2[COUNT_BITS-1:0];
            nx.q_g   = {it.q_g[FRAC_BITS-2:0], 1'b0};
        end
        return nx;
    endfunction

    // one restoring step of minb / (minb + ming)
    function automatic prob_item_t prob_step(input prob_item_t it);
        prob_item_t        nx;
        logic [DEN_BITS:0] r2;
        nx = it;
        r2 = {it.rem, 1'b0};
        if (r2 >= {1'b0, it.den})
        begin
            nx.rem = DEN_BITS'(r2 - {1'b0, it.den});
            nx.q   = {it.q[FRAC_BITS-2:0], 1'b1};
        end
        else
        begin
            nx.rem = r2[DEN_BITS-1:0];
            nx.q   = {it.q[FRAC_BITS-2:0], 1'b0};
        end
        return nx;
    endfunction

endpackage

@@ design/tsp_in_if.sv @@
interface tsp_in_if;
    logic                           valid;
    logic                           ready;
    logic [tsp_pkg::COUNT_BITS-1:0] ham_count;
    logic [tsp_pkg::COUNT_BITS-1:0] spam_count;

    modport source (output valid, output ham_count, output spam_count, input ready);
    modport sink (input valid, input ham_count, input spam_count, output ready);
endinterface

@@ design/tsp_out_if.sv @@
interface tsp_out_if;
    logic                          valid;
    logic                          ready;
    logic [tsp_pkg::FRAC_BITS-1:0] probability;
    logic                          insufficient;

    modport source (output valid, output probability, output insufficient, input ready);
    modport sink (input valid, input probability, input insufficient, output ready);
endinterface

@@ design/tsp_front.sv @@
module tsp_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             in_valid,
    input  logic [tsp_pkg::COUNT_BITS-1:0]   ham_count,
    input  logic [tsp_pkg::COUNT_BITS-1:0]   spam_count,
    input  logic [tsp_pkg::COUNT_BITS-1:0]   total_ham,
    input  logic [tsp_pkg::COUNT_BITS-1:0]   total_spam,
    input  logic [tsp_pkg::MIN_OCC_BITS-1:0] min_occ,
    output logic                             out_valid,
    output tsp_pkg::ratio_item_t             out_item
);

    logic                           valid_reg;
    tsp_pkg::ratio_item_t           item_reg;
    tsp_pkg::ratio_item_t           item_next;
    logic [tsp_pkg::COUNT_BITS:0]   g;
    logic [tsp_pkg::COUNT_BITS+1:0] wsum;

    always_comb
    begin
        g    = {ham_count, 1'b0};
        wsum = {1'b0, g} + {2'b00, spam_count};
        item_next.insuf  = wsum < (tsp_pkg::COUNT_BITS + 2)'(min_occ);
        // a zero count gives zero even against a zero total
        item_next.b_zero = spam_count == '0;
        item_next.b_one  = (spam_count != '0) && (spam_count >= total_spam);
        item_next.g_zero = ham_count == '0;
        item_next.g_one  = (ham_count != '0) && (g >= {1'b0, total_ham});
        item_next.rem_b  = spam_count;
        item_next.rem_g  = g[tsp_pkg::COUNT_BITS-1:0];
        item_next.q_b    = '0;
        item_next.q_g    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ design/tsp_ratio_div.sv @@
module tsp_ratio_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  tsp_pkg::ratio_item_t           in_item,
    input  logic [tsp_pkg::COUNT_BITS-1:0] total_ham,
    input  logic [tsp_pkg::COUNT_BITS-1:0] total_spam,
    output logic                           out_valid,
    output tsp_pkg::ratio_item_t           out_item
);

    localparam int N = tsp_pkg::FRAC_BITS;

    logic [N-1:0]         valid_reg;
    tsp_pkg::ratio_item_t item_reg  [N];
    tsp_pkg::ratio_item_t item_next [N];

    // one quotient bit of each ratio per stage
    always_comb
    begin
        item_next[0] = tsp_pkg::ratio_step(in_item, total_spam, total_ham);
        for (int i = 1; i < N; i++)
        begin
            item_next[i] = tsp_pkg::ratio_step(item_reg[i-1], total_spam, total_ham);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N; i++)
            begin
                item_reg[i] <= item_next[i];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_item  = item_reg[N-1];

endmodule

@@ design/tsp_prob_div.sv @@
module tsp_prob_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  tsp_pkg::ratio_item_t in_item,
    output logic                 out_valid,
    output tsp_pkg::prob_item_t  out_item
);

    localparam int N = tsp_pkg::FRAC_BITS;

    logic [tsp_pkg::RATIO_BITS-1:0] minb;
    logic [tsp_pkg::RATIO_BITS-1:0] ming;
    logic [tsp_pkg::DEN_BITS-1:0]   den;
    tsp_pkg::prob_item_t            setup_next;
    tsp_pkg::prob_item_t            setup_reg;
    logic                           setup_valid_reg;
    logic [N-1:0]                   valid_reg;
    tsp_pkg::prob_item_t            item_reg  [N];
    tsp_pkg::prob_item_t            item_next [N];

    always_comb
    begin
        if (in_item.b_zero)
        begin
            minb = '0;
        end
        else if (in_item.b_one)
        begin
            minb = tsp_pkg::ONE_FX;
        end
        else
        begin
            minb = {1'b0, in_item.q_b};
        end
        if (in_item.g_zero)
        begin
            ming = '0;
        end
        else if (in_item.g_one)
        begin
            ming = tsp_pkg::ONE_FX;
        end
        else
        begin
            ming = {1'b0, in_item.q_g};
        end
        den              = {1'b0, minb} + {1'b0, ming};
        setup_next.insuf = in_item.insuf;
        setup_next.half  = den == '0;
        // no ham weight: quotient is exactly one, clamped later
        setup_next.hi    = ming == '0;
        setup_next.rem   = {1'b0, minb};
        setup_next.den   = den;
        setup_next.q     = '0;
    end

    always_comb
    begin
        item_next[0] = tsp_pkg::prob_step(setup_reg);
        for (int i = 1; i < N; i++)
        begin
            item_next[i] = tsp_pkg::prob_step(item_reg[i-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_valid_reg <= 1'b0;
            valid_reg       <= '0;
        end
        else if (adv)
        begin
            setup_valid_reg <= in_valid;
            valid_reg       <= {valid_reg[N-2:0], setup_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            setup_reg <= setup_next;
            for (int i = 0; i < N; i++)
            begin
                item_reg[i] <= item_next[i];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_item  = item_reg[N-1];

endmodule

@@ design/token_spam_probability.sv @@
// Token spam probability scorer.
// Channel token (valid/ready) carries one token's ham_count and spam_count per beat;
// channel result carries its spam probability in unsigned Q0.16, clamped to
// 655..64880, or insufficient = 1 with probability 0 when 2*ham_count + spam_count
// is below min_occurrences.
// Configuration: cfg_write with cfg_index 0 = total_ham_messages,
// 1 = total_spam_messages, 2 = min_occurrences, data in cfg_data; change it only
// while no beat is in flight.
// The input stage loads at the accepting edge, then come 16 stages of the two ratio
// dividers (one quotient bit per stage), one sum stage, 16 stages of the probability
// divider and the output register. Throughput: one beat per cycle while the skid
// register is empty, set by the bit-per-stage dividers.
// Reset clears every valid bit and loads totals 1, 1 and minimum 5.
// When the receiver stalls, the output register holds its beat and a skid register
// takes one more; ready then drops and the whole pipeline holds until the output
// frees up. Nothing is dropped or repeated.
module token_spam_probability (
    input  logic                              clk,
    input  logic                              rst_n,
    tsp_in_if.sink                            token,
    tsp_out_if.source                         result,
    input  logic                              cfg_write,
    input  logic [tsp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tsp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    logic [tsp_pkg::COUNT_BITS-1:0]   total_ham_reg;
    logic [tsp_pkg::COUNT_BITS-1:0]   total_spam_reg;
    logic [tsp_pkg::MIN_OCC_BITS-1:0] min_occ_reg;

    logic                 adv;
    logic                 front_valid;
    tsp_pkg::ratio_item_t front_item;
    logic                 ratio_valid;
    tsp_pkg::ratio_item_t ratio_item;
    logic                 fin_valid;
    tsp_pkg::prob_item_t  fin_item;

    logic [tsp_pkg::FRAC_BITS-1:0] fin_prob;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [tsp_pkg::FRAC_BITS-1:0] out_prob_reg;
    logic                          out_insuf_reg;
    logic                          skid_valid_reg;
    logic                          skid_valid_next;
    logic [tsp_pkg::FRAC_BITS-1:0] skid_prob_reg;
    logic                          skid_insuf_reg;
    logic                          out_free;
    logic                          out_load_skid;
    logic                          out_load_fin;
    logic                          skid_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_ham_reg  <= tsp_pkg::TOTAL_RESET;
            total_spam_reg <= tsp_pkg::TOTAL_RESET;
            min_occ_reg    <= tsp_pkg::MIN_OCC_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tsp_pkg::CFG_TOTAL_HAM:  total_ham_reg  <= cfg_data[tsp_pkg::COUNT_BITS-1:0];
                tsp_pkg::CFG_TOTAL_SPAM: total_spam_reg <= cfg_data[tsp_pkg::COUNT_BITS-1:0];
                tsp_pkg::CFG_MIN_OCC:    min_occ_reg    <= cfg_data[tsp_pkg::MIN_OCC_BITS-1:0];
                default:                 ;
            endcase
        end
    end

    // pipeline moves whenever the skid register is empty
    assign adv         = !skid_valid_reg;
    assign token.ready = adv;

    tsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (token.valid),
        .ham_count  (token.ham_count),
        .spam_count (token.spam_count),
        .total_ham  (total_ham_reg),
        .total_spam (total_spam_reg),
        .min_occ    (min_occ_reg),
        .out_valid  (front_valid),
        .out_item   (front_item)
    );

    tsp_ratio_div u_ratio_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (front_valid),
        .in_item    (front_item),
        .total_ham  (total_ham_reg),
        .total_spam (total_spam_reg),
        .out_valid  (ratio_valid),
        .out_item   (ratio_item)
    );

    tsp_prob_div u_prob_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (ratio_valid),
        .in_item   (ratio_item),
        .out_valid (fin_valid),
        .out_item  (fin_item)
    );

    always_comb
    begin
        priority if (fin_item.insuf)
        begin
            fin_prob = '0;
        end
        else if (fin_item.half)
        begin
            fin_prob = tsp_pkg::HALF_FX;
        end
        else if (fin_item.hi || (fin_item.q > tsp_pkg::PROB_HI))
        begin
            fin_prob = tsp_pkg::PROB_HI;
        end
        else if (fin_item.q < tsp_pkg::PROB_LO)
        begin
            fin_prob = tsp_pkg::PROB_LO;
        end
        else
        begin
            fin_prob = fin_item.q;
        end
    end

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load_skid   = 1'b0;
        out_load_fin    = 1'b0;
        skid_load       = 1'b0;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_load_skid   = 1'b1;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_load_fin   = 1'b1;
                out_valid_next = fin_valid;
            end
        end
        else if (!skid_valid_reg)
        begin
            skid_load       = 1'b1;
            skid_valid_next = fin_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_skid)
        begin
            out_prob_reg  <= skid_prob_reg;
            out_insuf_reg <= skid_insuf_reg;
        end
        else if (out_load_fin)
        begin
            out_prob_reg  <= fin_prob;
            out_insuf_reg <= fin_item.insuf;
        end
        if (skid_load)
        begin
            skid_prob_reg  <= fin_prob;
            skid_insuf_reg <= fin_item.insuf;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.probability  = out_prob_reg;
    assign result.insufficient = out_insuf_reg;

endmodule

@@ design/tsp_checker.sv @@
`include "assert_macros.svh"

module tsp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [tsp_pkg::FRAC_BITS-1:0] probability,
    input logic                          insufficient
);

    // a stalled result beat keeps its payload
    `TSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(probability) && $stable(insufficient))

    `TSP_ASSERT_SAME(a_insuf_zero, clk, rst_n, out_valid && insufficient, probability == '0)

    `TSP_ASSERT_SAME(a_prob_range, clk, rst_n, out_valid && !insufficient, (probability >= tsp_pkg::PROB_LO) && (probability <= tsp_pkg::PROB_HI))

    // input backpressure only comes from a held result beat
    `TSP_ASSERT_SAME(a_ready_low, clk, rst_n, !in_ready, out_valid)

endmodule

bind token_spam_probability tsp_checker u_tsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (token.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .probability  (result.probability),
    .insufficient (result.insufficient)
);

@@ tb/sv/token_spam_probability_test.sv @@
module token_spam_probability_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_BITS     = tsp_pkg::COUNT_BITS;
    localparam int FRAC_BITS      = tsp_pkg::FRAC_BITS;
    localparam int MIN_OCC_BITS   = tsp_pkg::MIN_OCC_BITS;
    localparam int CFG_INDEX_BITS = tsp_pkg::CFG_INDEX_BITS;
    localparam int CFG_DATA_BITS  = tsp_pkg::CFG_DATA_BITS;

    localparam int          HALF_PERIOD = 4;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          DRAIN_TAIL  = 40;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [MIN_OCC_BITS-1:0] MIN_OCC_MAX = '1;

    typedef struct packed {
        logic [COUNT_BITS-1:0] ham;
        logic [COUNT_BITS-1:0] spam;
        logic [FRAC_BITS-1:0]  probability;
        logic                  insufficient;
    } score_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    tsp_in_if  token_ch();
    tsp_out_if result_ch();

    token_spam_probability dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .token     (token_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local copy of the trained totals and threshold
    logic [COUNT_BITS-1:0]   total_ham;
    logic [COUNT_BITS-1:0]   total_spam;
    logic [MIN_OCC_BITS-1:0] min_occ;

    score_t      pending_scores[$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned idle_pct;
    int unsigned stall_pct;

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= stall_pct);

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // q1.16 ratio of count over total, saturating at one
    function automatic logic [63:0] count_ratio(input logic [63:0] count,
                                                input logic [63:0] total);
        logic [63:0] q;
        if (total == 0)
            return (count != 0) ? (64'd1 << FRAC_BITS) : 64'd0;
        if (count >= total)
            return 64'd1 << FRAC_BITS;
        q = (count << FRAC_BITS) / total;
        return (q > (64'd1 << FRAC_BITS)) ? (64'd1 << FRAC_BITS) : q;
    endfunction

    function automatic score_t score_token(input logic [COUNT_BITS-1:0] ham,
                                           input logic [COUNT_BITS-1:0] spam);
        score_t      s;
        logic [63:0] g;
        logic [63:0] b;
        logic [63:0] rb;
        logic [63:0] rg;
        logic [63:0] den;
        logic [63:0] p;
        s.ham  = ham;
        s.spam = spam;
        g = 64'(ham) * 2;
        b = 64'(spam);
        if (g + b < 64'(min_occ))
        begin
            s.probability  = '0;
            s.insufficient = 1'b1;
            return s;
        end
        rb  = count_ratio(b, 64'(total_spam));
        rg  = count_ratio(g, 64'(total_ham));
        den = rb + rg;
        if (den == 0)
            p = 64'(tsp_pkg::HALF_FX);
        else
            p = (rb << FRAC_BITS) / den;
        if (p > 64'(tsp_pkg::PROB_HI))
            p = 64'(tsp_pkg::PROB_HI);
        if (p < 64'(tsp_pkg::PROB_LO))
            p = 64'(tsp_pkg::PROB_LO);
        s.probability  = p[FRAC_BITS-1:0];
        s.insufficient = 1'b0;
        return s;
    endfunction

    always @(posedge clk)
    begin
        score_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_scores.size() == 0)
                report_mismatch($sformatf("result beat p=%0d insuf=%0b with nothing pending",
                                          result_ch.probability, result_ch.insufficient));
            else
            begin
                want = pending_scores.pop_front();
                if (result_ch.probability !== want.probability)
                    report_mismatch($sformatf("ham=%0d spam=%0d probability %0d, expected %0d",
                                              want.ham, want.spam, result_ch.probability,
                                              want.probability));
                if (result_ch.insufficient !== want.insufficient)
                    report_mismatch($sformatf("ham=%0d spam=%0d insufficient %0b, expected %0b",
                                              want.ham, want.spam, result_ch.insufficient,
                                              want.insufficient));
            end
        end
    end

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            tsp_pkg::CFG_TOTAL_HAM:  total_ham  = value[COUNT_BITS-1:0];
            tsp_pkg::CFG_TOTAL_SPAM: total_spam = value[COUNT_BITS-1:0];
            tsp_pkg::CFG_MIN_OCC:    min_occ    = value[MIN_OCC_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(input logic [COUNT_BITS-1:0] ham_total,
                              input logic [COUNT_BITS-1:0] spam_total,
                              input logic [MIN_OCC_BITS-1:0] threshold);
        write_register(tsp_pkg::CFG_TOTAL_HAM, CFG_DATA_BITS'(ham_total));
        write_register(tsp_pkg::CFG_TOTAL_SPAM, CFG_DATA_BITS'(spam_total));
        write_register(tsp_pkg::CFG_MIN_OCC, CFG_DATA_BITS'(threshold));
    endtask

    // valid is left high after the beat; an idle cycle in the next call or drain_results lowers it
    task automatic send_token(input logic [COUNT_BITS-1:0] ham,
                              input logic [COUNT_BITS-1:0] spam);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            token_ch.valid      <= 1'b0;
            token_ch.ham_count  <= COUNT_BITS'($urandom);
            token_ch.spam_count <= COUNT_BITS'($urandom);
        end
        @(negedge clk);
        token_ch.valid      <= 1'b1;
        token_ch.ham_count  <= ham;
        token_ch.spam_count <= spam;
        do
            @(posedge clk);
        while (!token_ch.ready);
        pending_scores.insert(pending_scores.size(), score_token(ham, spam));
    endtask

    task automatic drain_results();
        @(negedge clk);
        token_ch.valid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [COUNT_BITS-1:0] pick_count(input logic [COUNT_BITS-1:0] near);
        int unsigned w;
        case ($urandom_range(3))
            0: return COUNT_BITS'($urandom);
            1:
            begin
                w = $urandom_range(COUNT_BITS, 1);
                return COUNT_BITS'($urandom & ((32'h1 << w) - 1));
            end
            2: return near + COUNT_BITS'($urandom_range(4)) - COUNT_BITS'(2);
            default: return COUNT_BITS'($urandom_range(300));
        endcase
    endfunction

    function automatic logic [COUNT_BITS-1:0] pick_total();
        case ($urandom_range(5))
            0: return '0;
            1: return COUNT_BITS'(1);
            2: return COUNT_MAX;
            3: return COUNT_BITS'($urandom_range(1000));
            default: return COUNT_BITS'($urandom & ((32'h1 << $urandom_range(COUNT_BITS, 1)) - 1));
        endcase
    endfunction

    // thresholds, saturated ratios and the clamps at the reset settings
    task automatic test_reset_defaults();
        send_token(0, 0);
        send_token(0, 4);
        send_token(0, 5);
        send_token(2, 1);
        send_token(3, 0);
        send_token(2, 0);
        send_token(1, 3);
        send_token(COUNT_MAX, COUNT_MAX);
        send_token(COUNT_MAX, 0);
        send_token(0, COUNT_MAX);
        drain_results();
    endtask

    // huge totals: both ratios can truncate to zero
    task automatic test_saturated_totals();
        set_config(COUNT_MAX, COUNT_MAX, 0);
        send_token(0, 0);
        send_token(1, 1);
        send_token(24'h800000, 24'h400000);
        send_token(COUNT_MAX, COUNT_MAX);
        drain_results();
    endtask

    task automatic test_zero_totals();
        set_config(0, 0, 0);
        send_token(0, 0);
        send_token(1, 0);
        send_token(0, 1);
        send_token(COUNT_MAX, COUNT_MAX);
        drain_results();
    endtask

    task automatic test_min_threshold();
        set_config(1000, 3000, MIN_OCC_MAX);
        send_token(0, 254);
        send_token(0, 255);
        send_token(127, 0);
        send_token(127, 1);
        send_token(128, 0);
        drain_results();
    endtask

    task automatic test_random_traffic(input int unsigned phase, input int unsigned count);
        case (phase % 4)
            0:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct  = 57;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct  = 0;
                stall_pct = 57;
            end
            default:
            begin
                idle_pct  = 12;
                stall_pct = 12;
            end
        endcase
        case (phase)
            0: set_config(COUNT_MAX, COUNT_MAX, 0);
            1: set_config(0, COUNT_MAX, MIN_OCC_MAX);
            2: set_config(1, 0, 5);
            3: set_config(1, 1, MIN_OCC_MAX);
            default: set_config(pick_total(), pick_total(),
                                MIN_OCC_BITS'($urandom_range(255)));
        endcase
        repeat (count)
            send_token(pick_count(total_ham >> 1), pick_count(total_spam));
        drain_results();
    endtask

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_write           = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        token_ch.valid      = 1'b0;
        token_ch.ham_count  = '0;
        token_ch.spam_count = '0;
        result_ch.ready     = 1'b0;
        total_ham           = tsp_pkg::TOTAL_RESET;
        total_spam          = tsp_pkg::TOTAL_RESET;
        min_occ             = tsp_pkg::MIN_OCC_RESET;
        mismatch_count      = 0;
        cycle_count         = 0;
        idle_pct            = 0;
        stall_pct           = 0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_saturated_totals();
        test_zero_totals();
        test_min_threshold();
        for (int unsigned phase = 0; phase < 8; phase++)
            test_random_traffic(phase, 144);

        repeat (DRAIN_TAIL)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/tsp_pkg.sv
design/tsp_in_if.sv
design/tsp_out_if.sv
design/tsp_front.sv
design/tsp_ratio_div.sv
design/tsp_prob_div.sv
design/token_spam_probability.sv
design/tsp_checker.sv
tb/sv/token_spam_probability_test.sv
